### hw/rtl/segment_intersection_point_macros.svh
// Assertion helpers for the segment intersection block.
`ifndef SEGMENT_INTERSECTION_POINT_MACROS_SVH
`define SEGMENT_INTERSECTION_POINT_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SIP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment intersection check failed");

// Next-cycle implication.
`define SIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment intersection check failed");

`endif

### hw/rtl/sip_pkg.sv
package sip_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // quotient bits: the offset magnitude never exceeds 2^w
    function automatic int quot_w(input int w);
        return w + 1;
    endfunction

    // normalized denominator magnitude, at most 2^(2w+1)
    function automatic int den_w(input int w);
        return 2 * w + 2;
    endfunction

    // dividend tn * |delta|, at most 2^(3w+1)
    function automatic int rem_w(input int w);
        return 3 * w + 3;
    endfunction

    // ax, ay, cx, cy, dx, dy, shape, hit, x negative, y negative
    function automatic int side_w(input int w);
        return 6 * w + 4;
    endfunction

endpackage

### hw/rtl/sip_in_if.sv
interface sip_in_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic [W-1:0] ax;
    logic [W-1:0] ay;
    logic [W-1:0] bx;
    logic [W-1:0] by_coord;
    logic [W-1:0] cx;
    logic [W-1:0] cy;
    logic [W-1:0] dx;
    logic [W-1:0] dy;
    logic         shape_edge;

    modport source (output valid, ax, ay, bx, by_coord, cx, cy, dx, dy, shape_edge,
                    input ready);
    modport sink (input valid, ax, ay, bx, by_coord, cx, cy, dx, dy, shape_edge,
                  output ready);
endinterface

### hw/rtl/sip_out_if.sv
interface sip_out_if #(
    parameter int W = 16
);
    logic         valid;
    logic         ready;
    logic         hit;
    logic         shape_flag;
    logic [W-1:0] px;
    logic [W-1:0] py;
    logic [W-1:0] corner_one_x;
    logic [W-1:0] corner_one_y;
    logic [W-1:0] corner_two_x;
    logic [W-1:0] corner_two_y;

    modport source (output valid, hit, shape_flag, px, py, corner_one_x, corner_one_y,
                    corner_two_x, corner_two_y, input ready);
    modport sink (input valid, hit, shape_flag, px, py, corner_one_x, corner_one_y,
                  corner_two_x, corner_two_y, output ready);
endinterface

### hw/rtl/sip_div_cell.sv
// One restoring-division step for both coordinates: decides quotient bit BIT.
module sip_div_cell import sip_pkg::*; #(
    parameter int W   = COORD_WIDTH_DEF,
    parameter int BIT = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_adv,
    input  logic                 i_adv,
    input  logic [den_w(W)-1:0]  i_den,
    input  logic [rem_w(W)-1:0]  i_rem_x,
    input  logic [rem_w(W)-1:0]  i_rem_y,
    input  logic [quot_w(W)-1:0] i_q_x,
    input  logic [quot_w(W)-1:0] i_q_y,
    input  logic [side_w(W)-1:0] i_side,
    output logic                 o_valid,
    output logic [den_w(W)-1:0]  o_den,
    output logic [rem_w(W)-1:0]  o_rem_x,
    output logic [rem_w(W)-1:0]  o_rem_y,
    output logic [quot_w(W)-1:0] o_q_x,
    output logic [quot_w(W)-1:0] o_q_y,
    output logic [side_w(W)-1:0] o_side
);
    localparam int RW = rem_w(W);
    localparam int QW = quot_w(W);

    logic          r_valid;
    logic [RW-1:0] w_sh;
    logic          w_ge_x, w_ge_y;
    logic [RW-1:0] n_rem_x, n_rem_y;
    logic [QW-1:0] n_q_x, n_q_y;

    assign o_adv  = !r_valid || i_adv;
    assign w_sh   = RW'(i_den) << BIT;
    assign w_ge_x = i_rem_x >= w_sh;
    assign w_ge_y = i_rem_y >= w_sh;

    always_comb begin
        n_rem_x = w_ge_x ? i_rem_x - w_sh : i_rem_x;
        n_rem_y = w_ge_y ? i_rem_y - w_sh : i_rem_y;
        n_q_x   = i_q_x | (QW'(w_ge_x) << BIT);
        n_q_y   = i_q_y | (QW'(w_ge_y) << BIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_valid) begin
            o_den   <= i_den;
            o_rem_x <= n_rem_x;
            o_rem_y <= n_rem_y;
            o_q_x   <= n_q_x;
            o_q_y   <= n_q_y;
            o_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
endmodule

### hw/rtl/segment_intersection_point.sv
// Channel | Dir | Carries
// i_req   | in  | ax, ay, bx, by_coord, cx, cy, dx, dy, shape_edge
// o_res   | out | hit, shape_flag, px, py, corner_one_x/y, corner_two_x/y
//
// One request per cycle is sustained while the output is not stalled.
// The depth comes from the row of division cells, one per quotient bit
// (COORD_WIDTH + 1 of them), behind four arithmetic stages and ahead of the
// output register.
// Reset (synchronous, active low) clears only the stage valid bits.
// Each stage moves on when the one after it is empty or moving, so a stalled
// output lets bubbles fill up behind it and input keeps flowing meanwhile.
`include "segment_intersection_point_macros.svh"

module segment_intersection_point import sip_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    sip_in_if.sink                      i_req,
    sip_out_if.source                   o_res
);
    localparam int W   = COORD_WIDTH;
    localparam int DW  = 2 * W + 3;     // signed cross product
    localparam int PW  = 2 * W + 2;     // signed single product
    localparam int DNW = den_w(W);
    localparam int RW  = rem_w(W);
    localparam int QW  = quot_w(W);
    localparam int SW  = side_w(W);

    // ---------------- stage 1: differences ----------------
    logic                 r_s1_valid, adv1;
    logic signed [W:0]    r_s1_rx, r_s1_ry, r_s1_sx, r_s1_sy, r_s1_qx, r_s1_qy;
    logic [W-1:0]         r_s1_ax, r_s1_ay, r_s1_cx, r_s1_cy, r_s1_dx, r_s1_dy;
    logic                 r_s1_shape;

    // ---------------- stage 2: products ----------------
    logic                 r_s2_valid, adv2;
    logic signed [PW-1:0] r_s2_p0, r_s2_p1, r_s2_p2, r_s2_p3, r_s2_p4, r_s2_p5;
    logic signed [W:0]    r_s2_rx, r_s2_ry;
    logic [W-1:0]         r_s2_ax, r_s2_ay, r_s2_cx, r_s2_cy, r_s2_dx, r_s2_dy;
    logic                 r_s2_shape;

    // ---------------- stage 3: hit test ----------------
    logic                 r_s3_valid, adv3;
    logic [DNW-1:0]       r_s3_den, r_s3_tn;
    logic [W:0]           r_s3_mx, r_s3_my;
    logic [SW-1:0]        r_s3_side;

    // ---------------- stage 4: dividends ----------------
    logic                 r_s4_valid, adv4;
    logic [DNW-1:0]       r_s4_den;
    logic [RW-1:0]        r_s4_rem_x, r_s4_rem_y;
    logic [SW-1:0]        r_s4_side;

    // ---------------- output register ----------------
    logic                 r_out_valid, adv_out;

    // ---------------- division cell row links ----------------
    logic                 c_valid [QW+1];
    logic                 c_adv   [QW+1];
    logic [DNW-1:0]       c_den   [QW+1];
    logic [RW-1:0]        c_rem_x [QW+1];
    logic [RW-1:0]        c_rem_y [QW+1];
    logic [QW-1:0]        c_q_x   [QW+1];
    logic [QW-1:0]        c_q_y   [QW+1];
    logic [SW-1:0]        c_side  [QW+1];

    logic signed [DW-1:0] w_den, w_tn, w_un, w_den_n, w_tn_n, w_un_n;
    logic                 w_hit, w_den_zero;

    assign adv_out     = !r_out_valid || o_res.ready;
    assign adv4        = !r_s4_valid || c_adv[0];
    assign adv3        = !r_s3_valid || adv4;
    assign adv2        = !r_s2_valid || adv3;
    assign adv1        = !r_s1_valid || adv2;
    assign i_req.ready = adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv1)    r_s1_valid  <= i_req.valid;
            if (adv2)    r_s2_valid  <= r_s1_valid;
            if (adv3)    r_s3_valid  <= r_s2_valid;
            if (adv4)    r_s4_valid  <= r_s3_valid;
            if (adv_out) r_out_valid <= c_valid[QW];
        end
    end

    // r = B - A, s = D - C, q = C - A, one bit wider so nothing wraps
    always_ff @(posedge i_clk) begin
        if (adv1 && i_req.valid) begin
            r_s1_rx    <= $signed({i_req.bx[W-1], i_req.bx}) -
                          $signed({i_req.ax[W-1], i_req.ax});
            r_s1_ry    <= $signed({i_req.by_coord[W-1], i_req.by_coord}) -
                          $signed({i_req.ay[W-1], i_req.ay});
            r_s1_sx    <= $signed({i_req.dx[W-1], i_req.dx}) -
                          $signed({i_req.cx[W-1], i_req.cx});
            r_s1_sy    <= $signed({i_req.dy[W-1], i_req.dy}) -
                          $signed({i_req.cy[W-1], i_req.cy});
            r_s1_qx    <= $signed({i_req.cx[W-1], i_req.cx}) -
                          $signed({i_req.ax[W-1], i_req.ax});
            r_s1_qy    <= $signed({i_req.cy[W-1], i_req.cy}) -
                          $signed({i_req.ay[W-1], i_req.ay});
            r_s1_ax    <= i_req.ax;
            r_s1_ay    <= i_req.ay;
            r_s1_cx    <= i_req.cx;
            r_s1_cy    <= i_req.cy;
            r_s1_dx    <= i_req.dx;
            r_s1_dy    <= i_req.dy;
            r_s1_shape <= i_req.shape_edge;
        end
    end

    // six signed products for den = r x s, tn = q x s, un = q x r
    always_ff @(posedge i_clk) begin
        if (adv2 && r_s1_valid) begin
            r_s2_p0    <= r_s1_rx * r_s1_sy;
            r_s2_p1    <= r_s1_sx * r_s1_ry;
            r_s2_p2    <= r_s1_qx * r_s1_sy;
            r_s2_p3    <= r_s1_sx * r_s1_qy;
            r_s2_p4    <= r_s1_qx * r_s1_ry;
            r_s2_p5    <= r_s1_rx * r_s1_qy;
            r_s2_rx    <= r_s1_rx;
            r_s2_ry    <= r_s1_ry;
            r_s2_ax    <= r_s1_ax;
            r_s2_ay    <= r_s1_ay;
            r_s2_cx    <= r_s1_cx;
            r_s2_cy    <= r_s1_cy;
            r_s2_dx    <= r_s1_dx;
            r_s2_dy    <= r_s1_dy;
            r_s2_shape <= r_s1_shape;
        end
    end

    // Flip signs so den > 0; then 0 <= t,u <= 1 is tn,un in [0, den].
    always_comb begin
        w_den      = DW'(r_s2_p0) - DW'(r_s2_p1);
        w_tn       = DW'(r_s2_p2) - DW'(r_s2_p3);
        w_un       = DW'(r_s2_p4) - DW'(r_s2_p5);
        w_den_n    = w_den[DW-1] ? -w_den : w_den;
        w_tn_n     = w_den[DW-1] ? -w_tn  : w_tn;
        w_un_n     = w_den[DW-1] ? -w_un  : w_un;
        w_den_zero = (w_den == '0);
        w_hit      = !w_den_zero && !w_tn_n[DW-1] && !w_un_n[DW-1] &&
                     (w_tn_n <= w_den_n) && (w_un_n <= w_den_n);
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_s2_valid) begin
            r_s3_den  <= w_den_n[DNW-1:0];
            r_s3_tn   <= w_tn_n[DNW-1:0];
            r_s3_mx   <= r_s2_rx[W] ? (W+1)'(-r_s2_rx) : (W+1)'(r_s2_rx);
            r_s3_my   <= r_s2_ry[W] ? (W+1)'(-r_s2_ry) : (W+1)'(r_s2_ry);
            r_s3_side <= {r_s2_ax, r_s2_ay, r_s2_cx, r_s2_cy, r_s2_dx, r_s2_dy,
                          r_s2_shape, w_hit, r_s2_rx[W], r_s2_ry[W]};
        end
    end

    // dividends tn * |r|, divided by den in the cell row
    always_ff @(posedge i_clk) begin
        if (adv4 && r_s3_valid) begin
            r_s4_den   <= r_s3_den;
            r_s4_rem_x <= RW'(r_s3_tn) * RW'(r_s3_mx);
            r_s4_rem_y <= RW'(r_s3_tn) * RW'(r_s3_my);
            r_s4_side  <= r_s3_side;
        end
    end

    // ---------------- division cell row, MSB first ----------------
    assign c_valid[0] = r_s4_valid;
    assign c_den[0]   = r_s4_den;
    assign c_rem_x[0] = r_s4_rem_x;
    assign c_rem_y[0] = r_s4_rem_y;
    assign c_q_x[0]   = '0;
    assign c_q_y[0]   = '0;
    assign c_side[0]  = r_s4_side;
    assign c_adv[QW]  = adv_out;

    for (genvar k = 0; k < QW; k++) begin : g_cell
        sip_div_cell #(
            .W   (W),
            .BIT (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[k]),
            .o_adv   (c_adv[k]),
            .i_adv   (c_adv[k+1]),
            .i_den   (c_den[k]),
            .i_rem_x (c_rem_x[k]),
            .i_rem_y (c_rem_y[k]),
            .i_q_x   (c_q_x[k]),
            .i_q_y   (c_q_y[k]),
            .i_side  (c_side[k]),
            .o_valid (c_valid[k+1]),
            .o_den   (c_den[k+1]),
            .o_rem_x (c_rem_x[k+1]),
            .o_rem_y (c_rem_y[k+1]),
            .o_q_x   (c_q_x[k+1]),
            .o_q_y   (c_q_y[k+1]),
            .o_side  (c_side[k+1])
        );
    end

    // ---------------- point and corner select ----------------
    logic [W-1:0] f_ax, f_ay, f_cx, f_cy, f_dx, f_dy;
    logic         f_shape, f_hit, f_negx, f_negy;
    logic [QW-1:0] f_offx, f_offy;
    logic [W-1:0] n_px, n_py;

    assign {f_ax, f_ay, f_cx, f_cy, f_dx, f_dy, f_shape, f_hit, f_negx, f_negy} =
        c_side[QW];

    always_comb begin
        f_offx = f_negx ? -c_q_x[QW] : c_q_x[QW];
        f_offy = f_negy ? -c_q_y[QW] : c_q_y[QW];
        n_px   = f_hit ? f_ax + f_offx[W-1:0] : '0;
        n_py   = f_hit ? f_ay + f_offy[W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && c_valid[QW]) begin
            o_res.hit          <= f_hit;
            o_res.shape_flag   <= f_shape;
            o_res.px           <= n_px;
            o_res.py           <= n_py;
            o_res.corner_one_x <= (f_hit && !f_shape) ? n_px : f_cx;
            o_res.corner_one_y <= (f_hit && !f_shape) ? n_py : f_cy;
            o_res.corner_two_x <= (f_hit && !f_shape) ? n_px : f_dx;
            o_res.corner_two_y <= (f_hit && !f_shape) ? n_py : f_dy;
        end
    end

    assign o_res.valid = r_out_valid;

    // ---------------- checks ----------------
    `SIP_ASSERT_NOW(a_miss_zero, o_res.valid && !o_res.hit,
                    o_res.px == '0 && o_res.py == '0)
    `SIP_ASSERT_NOW(a_border_pt, o_res.valid && o_res.hit && !o_res.shape_flag,
                    o_res.corner_one_x == o_res.px && o_res.corner_two_y == o_res.py)
    `SIP_ASSERT_NOW(a_par_miss, r_s2_valid && w_den_zero, !w_hit)
    `SIP_ASSERT_NEXT(a_hold_out, o_res.valid && !o_res.ready, o_res.valid)
endmodule

### tb/segment_intersection_point_test.sv
`timescale 1ns / 100ps

module segment_intersection_point_test import sip_pkg::*;;

    localparam int W = COORD_WIDTH_DEF;
    localparam int LATENCY = W + 6;
    // cycles with no request or result moving before the run is given up
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic [W-1:0] ax, ay, bx, by_coord, cx, cy, dx, dy;
        logic         shape_edge;
    } t_seg_pair;

    typedef struct packed {
        logic         hit;
        logic         shape_flag;
        logic [W-1:0] px, py;
        logic [W-1:0] c1x, c1y, c2x, c2y;
    } t_seg_point;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sip_in_if  #(.W(W)) req_if ();
    sip_out_if #(.W(W)) res_if ();

    segment_intersection_point #(.COORD_WIDTH(W)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    t_seg_point pending_points[$];
    int         error_count = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct;
    int         recv_stall_pct;

    always #6 i_clk = ~i_clk;

    // Exact intersection: cross products in 64 bits are wide enough for
    // 16-bit coordinates (tn * delta stays below 2^53).
    function automatic t_seg_point intersect_point(t_seg_pair p);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint rx, ry, sx, sy, qx, qy, den, tn, un;
        t_seg_point res;
        ax = longint'($signed(p.ax));  ay = longint'($signed(p.ay));
        bx = longint'($signed(p.bx));  by = longint'($signed(p.by_coord));
        cx = longint'($signed(p.cx));  cy = longint'($signed(p.cy));
        dx = longint'($signed(p.dx));  dy = longint'($signed(p.dy));
        rx = bx - ax;  ry = by - ay;
        sx = dx - cx;  sy = dy - cy;
        qx = cx - ax;  qy = cy - ay;
        den = rx * sy - sx * ry;
        tn  = qx * sy - sx * qy;
        un  = qx * ry - rx * qy;
        if (den < 0) begin
            den = -den;
            tn  = -tn;
            un  = -un;
        end
        res.shape_flag = p.shape_edge;
        res.hit = (den != 0) && (tn >= 0) && (un >= 0) && (tn <= den) && (un <= den);
        res.px  = '0;
        res.py  = '0;
        res.c1x = p.cx;  res.c1y = p.cy;
        res.c2x = p.dx;  res.c2y = p.dy;
        if (res.hit) begin
            // SV signed divide truncates toward zero
            res.px = W'(ax + (tn * rx) / den);
            res.py = W'(ay + (tn * ry) / den);
            if (!p.shape_edge) begin
                res.c1x = res.px;  res.c1y = res.py;
                res.c2x = res.px;  res.c2y = res.py;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                   input logic [W-1:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        error_count++;
    endtask

    // After an optional random idle gap, drive one request at a falling edge, hold it until it is taken.
    task automatic send_pair(input t_seg_pair p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.ax         <= p.ax;
        req_if.ay         <= p.ay;
        req_if.bx         <= p.bx;
        req_if.by_coord   <= p.by_coord;
        req_if.cx         <= p.cx;
        req_if.cy         <= p.cy;
        req_if.dx         <= p.dx;
        req_if.dy         <= p.dy;
        req_if.shape_edge <= p.shape_edge;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        pending_points.push_back(intersect_point(p));
        @(negedge i_clk);
    endtask

    // Sender holds off until the pipe has drained completely.
    task automatic drain_pause();
        req_if.valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_seg_pair make_pair(input int ax, ay, bx, by, cx, cy, dx, dy,
                                            input bit shape);
        t_seg_pair p;
        p.ax = W'(ax);  p.ay = W'(ay);  p.bx = W'(bx);  p.by_coord = W'(by);
        p.cx = W'(cx);  p.cy = W'(cy);  p.dx = W'(dx);  p.dy = W'(dy);
        p.shape_edge = shape;
        return p;
    endfunction

    // Random pair: full range, a tight window (lots of touching, parallel
    // and degenerate hits), a crossing through a box, or a forced parallel edge.
    function automatic t_seg_pair random_pair();
        t_seg_pair p;
        logic [159:0] raw;
        int lim, k;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        p = raw[$bits(t_seg_pair)-1:0];
        case ($urandom_range(5)) inside
            0, 1: ;
            2, 3: begin
                lim = $urandom_range(1) ? 6 : 200;
                p = make_pair($urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                              $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                              $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                              $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                              1'($urandom_range(1)));
            end
            4: begin
                // crossing through a box, endpoints at random points on its sides
                lim = $urandom_range(30000);
                p = make_pair(-lim, $urandom_range(2 * lim) - lim, lim,
                              $urandom_range(2 * lim) - lim, $urandom_range(2 * lim) - lim,
                              -lim, $urandom_range(2 * lim) - lim, lim,
                              1'($urandom_range(1)));
            end
            default: begin
                // edge parallel to the ray: D - C is a multiple of B - A
                k = $urandom_range(4) - 2;
                p = make_pair($urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                              $urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                              $urandom_range(2000) - 1000, $urandom_range(2000) - 1000,
                              0, 0, 1'($urandom_range(1)));
                p.dx = p.cx + W'(k * ($signed(p.bx) - $signed(p.ax)));
                p.dy = p.cy + W'(k * ($signed(p.by_coord) - $signed(p.ay)));
            end
        endcase
        return p;
    endfunction

    task automatic test_directed();
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, 1'b0));      // plain cross
        send_pair(make_pair(0, 0, 160, 160, 0, 160, 160, 0, 1'b1));      // shape hit
        send_pair(make_pair(0, 0, 3, 7, 1, 0, 0, 5, 1'b0));              // truncation
        send_pair(make_pair(0, 0, -3, -7, -1, 0, 0, -5, 1'b0));          // negative offsets
        send_pair(make_pair(0, 0, 16, 0, 0, 16, 16, 16, 1'b0));          // parallel
        send_pair(make_pair(0, 0, 16, 0, 32, 0, 48, 0, 1'b1));           // collinear
        send_pair(make_pair(0, 0, 16, 0, 4, 0, 12, 0, 1'b0));            // collinear overlap
        send_pair(make_pair(5, 5, 5, 5, 0, 0, 10, 10, 1'b0));            // A equals B
        send_pair(make_pair(0, 0, 10, 10, 5, 5, 5, 5, 1'b1));            // C equals D
        send_pair(make_pair(0, 0, 16, 0, 0, -8, 0, 8, 1'b0));            // t exactly 0
        send_pair(make_pair(0, 0, 16, 0, 16, -8, 16, 8, 1'b0));          // t exactly 1
        send_pair(make_pair(0, -8, 0, 8, 0, 0, 16, 0, 1'b1));            // u exactly 0
        send_pair(make_pair(16, -8, 16, 8, 0, 0, 16, 0, 1'b0));          // u exactly 1
        send_pair(make_pair(0, 0, 16, 0, 17, -8, 17, 8, 1'b0));          // just past end
        send_pair(make_pair(0, 0, 16, 0, 8, 1, 8, 9, 1'b1));             // misses u
        send_pair(make_pair(-32768, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768, 1'b0));        // full-range cross
        send_pair(make_pair(-32768, -32768, 32767, 32767,
                            -32768, 32767, 32767, -32768, 1'b1));
        send_pair(make_pair(32767, -32768, -32768, 32767,
                            -32768, -32768, 32767, 32767, 1'b0));
        send_pair(make_pair(-32768, 0, 32767, 0, 32767, -32768, 32767, 32767, 1'b0));
        send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1'b1));      // all ones
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));              // all zero
        drain_pause();
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            send_pair(random_pair());
            if (n == count / 2) drain_pause();
        end
    endtask

    // Result side: random backpressure set up at the falling edge.
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Result check and watchdog, both at the rising edge.
    always @(posedge i_clk) begin
        t_seg_point want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_points.size() == 0) begin
                $display("%0t unexpected result", $realtime);
                error_count++;
            end else begin
                want = pending_points.pop_front();
                if (res_if.hit !== want.hit)
                    report_mismatch("hit", W'(res_if.hit), W'(want.hit));
                if (res_if.shape_flag !== want.shape_flag)
                    report_mismatch("shape_flag", W'(res_if.shape_flag), W'(want.shape_flag));
                if (res_if.px !== want.px) report_mismatch("px", res_if.px, want.px);
                if (res_if.py !== want.py) report_mismatch("py", res_if.py, want.py);
                if (res_if.corner_one_x !== want.c1x)
                    report_mismatch("corner_one_x", res_if.corner_one_x, want.c1x);
                if (res_if.corner_one_y !== want.c1y)
                    report_mismatch("corner_one_y", res_if.corner_one_y, want.c1y);
                if (res_if.corner_two_x !== want.c2x)
                    report_mismatch("corner_two_x", res_if.corner_two_x, want.c2x);
                if (res_if.corner_two_y !== want.c2y)
                    report_mismatch("corner_two_y", res_if.corner_two_y, want.c2y);
            end
        end
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        req_if.valid      = 1'b0;
        req_if.ax         = '0;
        req_if.ay         = '0;
        req_if.bx         = '0;
        req_if.by_coord   = '0;
        req_if.cx         = '0;
        req_if.cy         = '0;
        req_if.dx         = '0;
        req_if.dy         = '0;
        req_if.shape_edge = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(350, 0, 0);
        test_random(350, 67, 0);
        test_random(350, 0, 67);
        test_random(350, 17, 17);

        req_if.valid <= 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
